FILE: hw/rtl/modem_prefix_stream_demux_core_macros.svh
// Assertion macros for the modem prefix stream demux checker.
// Needs a clock i_clk and an active-low reset i_rst_n in the using scope.
`ifndef MODEM_PREFIX_STREAM_DEMUX_CORE_MACROS_SVH
`define MODEM_PREFIX_STREAM_DEMUX_CORE_MACROS_SVH

// same-cycle implication
`define MPSD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MPSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/mpsd_pkg.sv
// Shared types and constants for the modem prefix stream demux.
// No dependencies.
package mpsd_pkg;

    localparam int HOLD_DEPTH_DEF = 8;
    localparam int CMD_DEPTH_DEF  = 4;

    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_M    = 8'h4D;
    localparam logic [7:0] CH_I    = 8'h49;
    localparam logic [7:0] CH_P    = 8'h50;
    localparam logic [7:0] CH_R    = 8'h52;
    localparam logic [7:0] CH_U    = 8'h55;
    localparam logic [7:0] CH_T    = 8'h54;
    localparam logic [7:0] CH_CR   = 8'h0D;

    localparam logic [1:0] DEST_GENERAL = 2'd0;
    localparam logic [1:0] DEST_UDP     = 2'd1;
    localparam logic [1:0] DEST_TCP     = 2'd2;

    typedef enum logic [1:0] {
        CMD_PASS  = 2'd0,
        CMD_HOLD  = 2'd1,
        CMD_FLUSH = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [1:0]  dest;
        logic [7:0]  data;
    } t_cmd;

endpackage

FILE: hw/rtl/mpsd_queue.sv
// Short command queue between the classifier and the output sequencer.
// Depends on mpsd_pkg.
module mpsd_queue #(
    parameter int DEPTH = mpsd_pkg::CMD_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  mpsd_pkg::t_cmd i_wr_data,
    output logic          o_full,
    input  logic          i_rd,
    output logic          o_valid,
    output mpsd_pkg::t_cmd o_rd_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    mpsd_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_wr, do_rd;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_rd_data = r_mem[r_rd_ptr];
    assign do_wr     = i_wr && !o_full;
    assign do_rd     = i_rd && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_wr) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : PW'(r_wr_ptr + PW'(1));
        end
        if (do_rd) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : PW'(r_rd_ptr + PW'(1));
        end
        if (do_wr && !do_rd) begin
            n_count = CW'(r_count + CW'(1));
        end else if (do_rd && !do_wr) begin
            n_count = CW'(r_count - CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

FILE: hw/rtl/mpsd_front.sv
// Classifier: tracks the +MIPR match and channel state, one command per byte.
// Depends on mpsd_pkg.
module mpsd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_take,
    input  logic [7:0]     i_byte,
    output mpsd_pkg::t_cmd o_cmd
);

    typedef enum logic [7:0] {
        MD_IDLE   = 8'b0000_0001,
        MD_PLUS   = 8'b0000_0010,
        MD_M      = 8'b0000_0100,
        MD_I      = 8'b0000_1000,
        MD_P      = 8'b0001_0000,
        MD_R      = 8'b0010_0000,
        MD_UDP    = 8'b0100_0000,
        MD_TCP    = 8'b1000_0000
    } t_mode;

    t_mode r_mode, n_mode;

    // partial-match step: hold and advance on the expected char, else flush to general
    function automatic logic step_ok(input logic [7:0] b, input logic [7:0] want);
        step_ok = (b == want);
    endfunction

    always_comb begin
        n_mode     = r_mode;
        o_cmd.kind = mpsd_pkg::CMD_PASS;
        o_cmd.dest = mpsd_pkg::DEST_GENERAL;
        o_cmd.data = i_byte;
        unique case (r_mode)
            MD_IDLE: begin
                if (i_byte == mpsd_pkg::CH_PLUS) begin
                    o_cmd.kind = mpsd_pkg::CMD_HOLD;
                    n_mode     = MD_PLUS;
                end
            end
            MD_PLUS: begin
                o_cmd.kind = step_ok(i_byte, mpsd_pkg::CH_M) ? mpsd_pkg::CMD_HOLD
                                                             : mpsd_pkg::CMD_FLUSH;
                n_mode     = step_ok(i_byte, mpsd_pkg::CH_M) ? MD_M : MD_IDLE;
            end
            MD_M: begin
                o_cmd.kind = step_ok(i_byte, mpsd_pkg::CH_I) ? mpsd_pkg::CMD_HOLD
                                                             : mpsd_pkg::CMD_FLUSH;
                n_mode     = step_ok(i_byte, mpsd_pkg::CH_I) ? MD_I : MD_IDLE;
            end
            MD_I: begin
                o_cmd.kind = step_ok(i_byte, mpsd_pkg::CH_P) ? mpsd_pkg::CMD_HOLD
                                                             : mpsd_pkg::CMD_FLUSH;
                n_mode     = step_ok(i_byte, mpsd_pkg::CH_P) ? MD_P : MD_IDLE;
            end
            MD_P: begin
                o_cmd.kind = step_ok(i_byte, mpsd_pkg::CH_R) ? mpsd_pkg::CMD_HOLD
                                                             : mpsd_pkg::CMD_FLUSH;
                n_mode     = step_ok(i_byte, mpsd_pkg::CH_R) ? MD_R : MD_IDLE;
            end
            MD_R: begin
                o_cmd.kind = mpsd_pkg::CMD_FLUSH;
                if (i_byte == mpsd_pkg::CH_U) begin
                    o_cmd.dest = mpsd_pkg::DEST_UDP;
                    n_mode     = MD_UDP;
                end else if (i_byte == mpsd_pkg::CH_T) begin
                    o_cmd.dest = mpsd_pkg::DEST_TCP;
                    n_mode     = MD_TCP;
                end else begin
                    n_mode     = MD_IDLE;
                end
            end
            MD_UDP: begin
                o_cmd.dest = mpsd_pkg::DEST_UDP;
                if (i_byte == mpsd_pkg::CH_CR) begin
                    n_mode = MD_IDLE;
                end
            end
            MD_TCP: begin
                o_cmd.dest = mpsd_pkg::DEST_TCP;
                if (i_byte == mpsd_pkg::CH_CR) begin
                    n_mode = MD_IDLE;
                end
            end
            default: begin
                n_mode = MD_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MD_IDLE;
        end else if (i_take) begin
            r_mode <= n_mode;
        end
    end

endmodule

FILE: hw/rtl/mpsd_back.sv
// Output sequencer: holds prefix bytes, replays them on a flush, drives the result register.
// Depends on mpsd_pkg.
module mpsd_back #(
    parameter int HOLD_DEPTH = mpsd_pkg::HOLD_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  mpsd_pkg::t_cmd i_cmd,
    output logic           o_cmd_take,
    input  logic           i_pop,
    output logic           o_empty,
    output logic [1:0]     o_destination,
    output logic [7:0]     o_byte_out,
    output logic           o_last
);

    localparam int IW = $clog2(HOLD_DEPTH);
    localparam int CW = $clog2(HOLD_DEPTH + 1);

    typedef enum logic [1:0] {
        BK_READY = 2'b01,
        BK_FLUSH = 2'b10
    } t_bk_state;

    t_bk_state     r_state, n_state;
    logic [7:0]    r_hold [HOLD_DEPTH];
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_len, n_len;
    logic [CW-1:0] r_idx, n_idx;
    logic [1:0]    r_fdest, n_fdest;
    logic          r_out_valid, n_out_valid;
    logic [1:0]    r_dest, n_dest;
    logic [7:0]    r_byte, n_byte;
    logic          r_last, n_last;
    logic          out_free, out_load, hold_wr, room;
    logic          flush_end;

    assign out_free  = !r_out_valid || i_pop;
    assign room      = (r_cnt < CW'(HOLD_DEPTH));
    assign flush_end = (CW'(r_idx + CW'(1)) == r_len);

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_len      = r_len;
        n_idx      = r_idx;
        n_fdest    = r_fdest;
        n_dest     = r_dest;
        n_byte     = r_byte;
        n_last     = r_last;
        o_cmd_take = 1'b0;
        out_load   = 1'b0;
        hold_wr    = 1'b0;
        unique case (r_state)
            BK_READY: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.kind)
                        mpsd_pkg::CMD_PASS: begin
                            if (out_free) begin
                                o_cmd_take = 1'b1;
                                out_load   = 1'b1;
                                n_dest     = i_cmd.dest;
                                n_byte     = i_cmd.data;
                                n_last     = 1'b1;
                            end
                        end
                        mpsd_pkg::CMD_HOLD: begin
                            o_cmd_take = 1'b1;
                            hold_wr    = room;
                            n_cnt      = room ? CW'(r_cnt + CW'(1)) : r_cnt;
                        end
                        mpsd_pkg::CMD_FLUSH: begin
                            // trigger byte is stored too when there is room, then the whole store replays
                            o_cmd_take = 1'b1;
                            hold_wr    = room;
                            n_len      = room ? CW'(r_cnt + CW'(1)) : r_cnt;
                            n_idx      = '0;
                            n_cnt      = '0;
                            n_fdest    = i_cmd.dest;
                            n_state    = BK_FLUSH;
                        end
                        default: begin
                            o_cmd_take = 1'b1;
                        end
                    endcase
                end
            end
            BK_FLUSH: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_dest   = r_fdest;
                    n_byte   = r_hold[r_idx[IW-1:0]];
                    n_last   = flush_end;
                    n_idx    = CW'(r_idx + CW'(1));
                    if (flush_end) begin
                        n_state = BK_READY;
                    end
                end
            end
            default: begin
                n_state = BK_READY;
            end
        endcase
        n_out_valid = out_load ? 1'b1 : (i_pop ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_READY;
            r_cnt       <= '0;
            r_idx       <= '0;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_idx       <= n_idx;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fdest <= n_fdest;
        r_dest  <= n_dest;
        r_byte  <= n_byte;
        r_last  <= n_last;
        if (hold_wr) begin
            r_hold[r_cnt[IW-1:0]] <= i_cmd.data;
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_destination = r_dest;
    assign o_byte_out    = r_byte;
    assign o_last        = r_last;

endmodule

FILE: hw/rtl/modem_prefix_stream_demux_core.sv
// Path: a pass-through byte goes into the command queue and then into the result register;
// the first word of a flush passes the queue, the flush state and then the result register.
// Throughput: one byte a cycle while passing through and popped; a flush keeps the output
// sequencer busy until it has replayed, and input stalls only once the command queue fills.
// The single result register sets the output rate at one result a cycle while it is popped.
// Reset (synchronous, active low) returns to idle general mode with empty queue and no
// held bytes; stored byte values are not cleared.
module modem_prefix_stream_demux_core #(
    parameter int HOLD_DEPTH = mpsd_pkg::HOLD_DEPTH_DEF,
    parameter int CMD_DEPTH  = mpsd_pkg::CMD_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_byte_in,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] o_destination,
    output logic [7:0] o_byte_out,
    output logic       o_last
);

    mpsd_pkg::t_cmd front_cmd;
    mpsd_pkg::t_cmd q_cmd;
    logic           q_full, q_valid, q_take, take;

    assign full = q_full;
    assign take = push && !q_full;

    mpsd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (i_byte_in),
        .o_cmd   (front_cmd)
    );

    mpsd_queue #(
        .DEPTH (CMD_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (take),
        .i_wr_data (front_cmd),
        .o_full    (q_full),
        .i_rd      (q_take),
        .o_valid   (q_valid),
        .o_rd_data (q_cmd)
    );

    mpsd_back #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (q_valid),
        .i_cmd         (q_cmd),
        .o_cmd_take    (q_take),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_destination (o_destination),
        .o_byte_out    (o_byte_out),
        .o_last        (o_last)
    );

endmodule

FILE: hw/rtl/mpsd_checker.sv
// Port-level checker for the modem prefix stream demux, bound to the top level.
// Depends on modem_prefix_stream_demux_core_macros.svh.
`include "modem_prefix_stream_demux_core_macros.svh"

module mpsd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       push,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [1:0] o_destination,
    input logic [7:0] o_byte_out,
    input logic       o_last
);

    `MPSD_ASSERT_NEXT(a_result_holds, !empty && !pop,
        !empty && $stable(o_byte_out) && $stable(o_destination) && $stable(o_last),
        "waiting result changed")
    `MPSD_ASSERT_NOW(a_dest_legal, !empty, o_destination != 2'd3, "illegal destination code")
    `MPSD_ASSERT_NEXT(a_burst_continues, !empty && pop && !o_last,
        !empty && o_destination == $past(o_destination), "flush burst broken")
    `MPSD_ASSERT_NOW(a_handshake_known, 1'b1, !$isunknown({push, full, pop, empty}),
        "handshake signal unknown")

endmodule

bind modem_prefix_stream_demux_core mpsd_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .push          (push),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .o_destination (o_destination),
    .o_byte_out    (o_byte_out),
    .o_last        (o_last)
);

FILE: bench/tb.sv
// Self-checking bench for modem_prefix_stream_demux_core: routing of +MIPR-prefixed modem bytes.
// Needs mpsd_pkg and the core; a queue-fed driver, a predictor in the monitor and a watchdog.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = 20;
    localparam int WORDS_PER_PHASE = 160;

    typedef enum logic [2:0] {
        RX_IDLE  = 3'd0,
        RX_PLUS  = 3'd1,
        RX_M     = 3'd2,
        RX_I     = 3'd3,
        RX_P     = 3'd4,
        RX_R     = 3'd5,
        RX_UDP   = 3'd6,
        RX_TCP   = 3'd7
    } t_rx_state;

    typedef struct {
        logic [1:0] dest;
        logic [7:0] data;
        logic       last;
    } t_routed_word;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       pop = 1'b0;
    logic [7:0] i_byte_in = 8'h00;
    logic       full;
    logic       empty;
    logic [1:0] o_destination;
    logic [7:0] o_byte_out;
    logic       o_last;

    logic [7:0]   pending_q[$];
    t_routed_word routed_q[$];

    t_rx_state  rx_state;
    logic [7:0] held_store[8];
    int         held_n;

    int send_idle_pct = 13;
    int recv_idle_pct = 73;
    int words_queued  = 0;
    int words_taken   = 0;
    int idle_cycles   = 0;
    int errors        = 0;

    logic byte_taken = 1'b0;

    modem_prefix_stream_demux_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_byte_in     (i_byte_in),
        .empty         (empty),
        .pop           (pop),
        .o_destination (o_destination),
        .o_byte_out    (o_byte_out),
        .o_last        (o_last)
    );

    initial forever #1 i_clk = ~i_clk;

    function automatic logic [7:0] prefix_char(int k);
        case (k)
            0:       return mpsd_pkg::CH_PLUS;
            1:       return mpsd_pkg::CH_M;
            2:       return mpsd_pkg::CH_I;
            3:       return mpsd_pkg::CH_P;
            default: return mpsd_pkg::CH_R;
        endcase
    endfunction

    function automatic void release_held(logic [1:0] dest);
        t_routed_word w;
        for (int i = 0; i < held_n && i < 6; i++) begin
            w.dest = dest;
            w.data = held_store[i];
            w.last = (i + 1 == held_n) || (i == 5);
            routed_q.push_back(w);
        end
        held_n = 0;
    endfunction

    // works out the words one input byte sends on, and advances the prefix matcher
    function automatic void route_byte(logic [7:0] b);
        t_routed_word w;
        if (rx_state == RX_UDP || rx_state == RX_TCP) begin
            w.dest = (rx_state == RX_UDP) ? mpsd_pkg::DEST_UDP : mpsd_pkg::DEST_TCP;
            w.data = b;
            w.last = 1'b1;
            routed_q.push_back(w);
            if (b == mpsd_pkg::CH_CR)
                rx_state = RX_IDLE;
        end else if (rx_state == RX_IDLE && b != mpsd_pkg::CH_PLUS) begin
            w.dest = mpsd_pkg::DEST_GENERAL;
            w.data = b;
            w.last = 1'b1;
            routed_q.push_back(w);
        end else begin
            if (held_n < 7) begin
                held_store[held_n] = b;
                held_n++;
            end
            if (rx_state == RX_R) begin
                if (b == mpsd_pkg::CH_U) begin
                    rx_state = RX_UDP;
                    release_held(mpsd_pkg::DEST_UDP);
                end else if (b == mpsd_pkg::CH_T) begin
                    rx_state = RX_TCP;
                    release_held(mpsd_pkg::DEST_TCP);
                end else begin
                    rx_state = RX_IDLE;
                    release_held(mpsd_pkg::DEST_GENERAL);
                end
            end else if (b == prefix_char(int'(rx_state))) begin
                rx_state = t_rx_state'(rx_state + 3'd1);
            end else begin
                rx_state = RX_IDLE;
                release_held(mpsd_pkg::DEST_GENERAL);
            end
        end
    endfunction

    task automatic queue_byte(logic [7:0] b);
        pending_q.push_back(b);
        words_queued++;
    endtask

    task automatic queue_text(string s);
        for (int i = 0; i < s.len(); i++)
            queue_byte(s[i]);
    endtask

    task automatic queue_prefix(int n);
        for (int k = 0; k < n; k++)
            queue_byte(prefix_char(k));
    endtask

    // one burst of traffic: mostly complete channel sessions, some broken prefixes and noise
    task automatic queue_burst();
        int sel;
        int len;
        sel = $urandom_range(99);
        if (sel < 15) begin
            len = $urandom_range(4, 1);
            repeat (len) queue_byte(8'($urandom_range(255)));
        end else if (sel < 40) begin
            queue_prefix($urandom_range(5, 1));
            if ($urandom_range(3) == 0)
                queue_byte(mpsd_pkg::CH_PLUS);
            else
                queue_byte(8'($urandom_range(255)));
        end else begin
            queue_prefix(5);
            queue_byte($urandom_range(1) ? mpsd_pkg::CH_U : mpsd_pkg::CH_T);
            len = $urandom_range(10);
            repeat (len) queue_byte(8'($urandom_range(255)));
            queue_byte(mpsd_pkg::CH_CR);
        end
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (words_taken != words_queued || routed_q.size() != 0);
    endtask

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
            pop  <= 1'b0;
        end else begin
            if (!push || (words_taken > 0 && byte_taken)) begin
                if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    push      <= 1'b1;
                    i_byte_in <= pending_q.pop_front();
                end else begin
                    push <= 1'b0;
                end
            end
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor: predicts on accepted bytes, then checks accepted words
    always @(posedge i_clk) begin
        t_routed_word exp_w;
        if (!i_rst_n) begin
            byte_taken  <= 1'b0;
            rx_state    = RX_IDLE;
            held_n      = 0;
            idle_cycles <= 0;
        end else begin
            byte_taken <= push && !full;
            if (push && !full) begin
                route_byte(i_byte_in);
                words_taken <= words_taken + 1;
            end
            if (pop && !empty) begin
                if (routed_q.size() == 0) begin
                    $error("unexpected word: destination %0d byte %02h last %0b",
                           o_destination, o_byte_out, o_last);
                    errors++;
                end else begin
                    exp_w = routed_q.pop_front();
                    if (o_destination !== exp_w.dest) begin
                        $error("destination: expected %0d, got %0d", exp_w.dest, o_destination);
                        errors++;
                    end
                    if (o_byte_out !== exp_w.data) begin
                        $error("byte_out: expected %02h, got %02h", exp_w.data, o_byte_out);
                        errors++;
                    end
                    if (o_last !== exp_w.last) begin
                        $error("last: expected %0b, got %0b", exp_w.last, o_last);
                        errors++;
                    end
                end
            end
            if ((push && !full) || (pop && !empty))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: byte extremes, both channels, mismatch after R with a stray plus
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_text("+M+");
        queue_text("+MIPRU");
        queue_byte(8'h7F);
        queue_byte(mpsd_pkg::CH_CR);
        queue_text("+MIPRT");
        queue_byte(mpsd_pkg::CH_CR);
        queue_text("+MIPR+");

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 13; recv_idle_pct = 73; end
                1: begin send_idle_pct = 73; recv_idle_pct = 13; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            while (words_queued < (phase + 1) * WORDS_PER_PHASE)
                queue_burst();
            // sender holds off here until every routed word has been taken
            wait_drained();
            @(posedge i_clk);
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0 && routed_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
